FILE: rtl/core/fba_pkg.sv
// Package for the frame bitmap allocator: field widths, status and request codes,
// register map, parameter defaults and the controller state type.
// Depends on nothing.
`default_nettype none

package fba_pkg;

	localparam int FRAME_W        = 12;
	localparam int STATUS_W       = 3;
	localparam int ACTIVE_W       = 13;
	localparam int DEF_NUM_FRAMES = 4096;
	localparam int DEF_WORD_BITS  = 32;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 13'd4096;

	// Register index, taken from paddr[2].
	localparam logic REG_ACTIVE_FRAMES = 1'b0;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd4;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FREE,
		FSM_DONE
	} fsm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/frame_bitmap_allocator.sv
// Frame bitmap allocator, first fit.
// Slave stream: one request per item (tuser = request type). Master stream: one result
// per request. APB port holds the active frame count (register 0).
// The used/free bitmap sits in one RAM, one word per row. A row valid bit per word,
// cleared at reset, makes every frame free at once: an unwritten row reads as zero.
// A new request is taken only when the previous one has been processed; a result may
// still wait in the output register while the next request is being worked on.
// Path from request accepted to result shown: an already held frame or nothing to
// free goes straight to the done state; a free reads its word and writes it back in
// the free state; an allocate scans the active words in order, stopping at the first
// word with a free frame, or after reading every active word when all are full; it
// finishes without a read when no word is active.
// The next request can be taken in the same cycle as the previous result is shown.
// The scan reads one bitmap word per cycle from the RAM read port; the hit word is
// modified and written back through the write port in the cycle its data arrives.
// Items are processed one at a time, so read and write of the same row never overlap.
// When the receiver stalls, the finished result holds in the output register and the
// next request stalls only when it is itself done.
// Reset clears the row valid bits (every frame free), sets the active count to 4096 and
// clears all handshake state; no clearing pass is needed.
`default_nettype none

module frame_bitmap_allocator
	import fba_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int WORD_BITS  = DEF_WORD_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [11:0] current_frame, [12] supervisor, [13] read_write, [15:14] zero
	input  wire logic [15:0] s_tdata,
	// [0] req_type
	input  wire logic        s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [11:0] frame_number, [12] present_flag, [13] writeable_flag,
	// [14] supervisor_flag, [17:15] status, [23:18] zero
	output      logic [23:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	localparam int STORED_WORDS = NUM_FRAMES / WORD_BITS;
	localparam int AW = (STORED_WORDS > 1) ? $clog2(STORED_WORDS) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int FW = AW + BW + 1;

	function automatic logic [BW-1:0] first_zero(input logic [WORD_BITS-1:0] bits);
		logic [BW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				idx = BW'(i);
			end
		end
		return idx;
	endfunction

	fsm_state_t state_q, state_d;

	logic [ACTIVE_W-1:0]  active_frames_q;
	logic [ACTIVE_W-1:0]  act_div;
	logic [AW:0]          act_words;
	logic [AW:0]          scan_addr_q;
	logic                 rd_pend_s1;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic [STORED_WORDS-1:0] row_valid_q;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic [WORD_BITS-1:0] word_eff;
	logic                 word_full;
	logic [BW-1:0]        zero_idx;
	logic [FW-1:0]        hit_frame;
	logic                 scan_hit;

	logic [FRAME_W-1:0]   in_frame;
	logic [FRAME_W-1:0]   in_word;
	logic                 in_word_ok;
	logic                 accept;
	logic                 cfg_wr;
	logic                 out_load;

	logic [BW-1:0]        fbit_q;
	logic                 sup_q, wr_q;
	logic [FRAME_W-1:0]   res_frame_q;
	logic                 res_present_q, res_wr_q, res_sup_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 m_tvalid_q;
	logic [23:0]          m_tdata_q;

	fba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STORED_WORDS),
		.AW   (AW)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_FRAMES);
	assign prdata = (paddr[2] == REG_ACTIVE_FRAMES) ? {19'b0, active_frames_q} : 32'b0;

	// Active words, capped at what the bitmap stores.
	assign act_div   = active_frames_q / ACTIVE_W'(WORD_BITS);
	assign act_words = ({19'b0, act_div} > 32'(STORED_WORDS)) ?
	                   (AW+1)'(STORED_WORDS) : (AW+1)'(act_div);

	assign in_frame   = s_tdata[FRAME_W-1:0];
	assign in_word    = in_frame / FRAME_W'(WORD_BITS);
	assign in_word_ok = {20'b0, in_word} < 32'(STORED_WORDS);
	assign s_tready   = (state_q == FSM_IDLE);
	assign accept     = s_tvalid && s_tready;

	// A row never written reads as all frames free.
	assign word_eff  = rd_vld_s1 ? ram_rdata : '0;
	assign word_full = &word_eff;
	assign zero_idx  = first_zero(word_eff);
	assign hit_frame = FW'(rd_addr_s1) * FW'(WORD_BITS) + FW'(zero_idx);
	assign scan_hit  = (state_q == FSM_SCAN) && rd_pend_s1 && !word_full;
	assign out_load  = (state_q == FSM_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = scan_addr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = word_eff | (WORD_BITS'(1) << zero_idx);
		case (state_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == REQ_ALLOC) begin
						state_d = (in_frame != '0) ? FSM_DONE : FSM_SCAN;
					end else if (in_frame != '0 && in_word_ok) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(in_word);
						state_d   = FSM_FREE;
					end else begin
						state_d = FSM_DONE;
					end
				end
			end
			FSM_SCAN: begin
				if (scan_hit) begin
					ram_we  = 1'b1;
					state_d = FSM_DONE;
				end else if (scan_addr_q < act_words) begin
					ram_re = 1'b1;
				end else if (!rd_pend_s1) begin
					state_d = FSM_DONE;
				end
			end
			FSM_FREE: begin
				ram_we    = 1'b1;
				ram_wdata = word_eff & ~(WORD_BITS'(1) << fbit_q);
				state_d   = FSM_DONE;
			end
			FSM_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= FSM_IDLE;
			active_frames_q <= ACTIVE_RESET;
			scan_addr_q     <= '0;
			rd_pend_s1      <= 1'b0;
			row_valid_q     <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			if (cfg_wr) begin
				active_frames_q <= pwdata[ACTIVE_W-1:0];
			end
			if (accept) begin
				scan_addr_q <= '0;
			end else if (ram_re) begin
				scan_addr_q <= scan_addr_q + (AW+1)'(1);
			end
			if (ram_we) begin
				row_valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
			rd_vld_s1  <= row_valid_q[ram_raddr];
		end
		if (accept) begin
			fbit_q        <= BW'(in_frame % FRAME_W'(WORD_BITS));
			sup_q         <= s_tdata[12];
			wr_q          <= s_tdata[13];
			res_present_q <= 1'b0;
			res_wr_q      <= 1'b0;
			res_sup_q     <= 1'b0;
			if (s_tuser == REQ_ALLOC) begin
				// A page with no frame carries frame zero, which is also the no-free result.
				res_frame_q  <= in_frame;
				res_status_q <= (in_frame != '0) ? ST_HELD : ST_NO_FREE;
			end else begin
				res_frame_q  <= '0;
				res_status_q <= (in_frame != '0) ? ST_FREED : ST_NOTHING;
			end
		end else if (scan_hit) begin
			res_frame_q   <= FRAME_W'(hit_frame);
			res_present_q <= 1'b1;
			res_wr_q      <= wr_q;
			res_sup_q     <= sup_q;
			res_status_q  <= ST_ALLOCATED;
		end
		if (out_load) begin
			m_tdata_q <= {6'b0, res_status_q, res_sup_q, res_wr_q, res_present_q,
			              res_frame_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The bitmap is written only by a scan hit or a free, each after its read.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == FSM_SCAN || state_q == FSM_FREE))
		else $error("bitmap written outside scan or free");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(ram_re))
		else $error("bitmap write without a preceding read");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == FSM_DONE))
		else $error("result shown without a finished request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN) |-> (scan_addr_q <= act_words))
		else $error("scan ran past the active words");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[12]) |-> (m_tdata[17:15] == ST_ALLOCATED))
		else $error("present flag without allocated status");

endmodule

`default_nettype wire

FILE: rtl/core/fba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: test/frame_bitmap_allocator_tb.sv
// Self-checking testbench for frame_bitmap_allocator: drives allocate and free requests,
// writes the active frame count over APB and checks every result against a local bitmap.
// Depends on fba_pkg and the frame_bitmap_allocator RTL only.
`timescale 1ns / 100ps

module frame_bitmap_allocator_tb;
	import fba_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int BITS_PER_WORD = DEF_WORD_BITS;
	localparam int BITMAP_WORDS  = DEF_NUM_FRAMES / DEF_WORD_BITS;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int END_CYCLES    = 140;
	localparam int MAX_PRINTS    = 50;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		logic                present;
		logic                writeable;
		logic                supervisor;
		logic [STATUS_W-1:0] status;
	} alloc_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [11:0] current_frame, [12] supervisor, [13] read_write, [15:14] zero
	logic [15:0] s_tdata  = '0;
	// [0] req_type
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [11:0] frame_number, [12] present_flag, [13] writeable_flag,
	// [14] supervisor_flag, [17:15] status, [23:18] zero
	logic [23:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Local copy of the allocator state.
	bit                  frame_used [DEF_NUM_FRAMES];
	logic [ACTIVE_W-1:0] frames_active = ACTIVE_RESET;

	alloc_result_t       pending_results[$];
	int                  held_frames[$];
	logic [STATUS_W-1:0] last_status;
	int                  fail_count    = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  hold_left     = 0;
	bit                  hold_go       = 1'b0;

	frame_bitmap_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	// First fit over the active words, which are capped at the stored bitmap size.
	function automatic alloc_result_t predict_request(input logic req,
			input logic [FRAME_W-1:0] cur, input logic sup, input logic wr);
		alloc_result_t r;
		int words;
		int hit;
		int f;
		r   = '0;
		hit = -1;
		if (req == REQ_ALLOC) begin
			if (cur != 0) begin
				r.frame  = cur;
				r.status = ST_HELD;
			end else begin
				words = int'(frames_active) / BITS_PER_WORD;
				if (words > BITMAP_WORDS)
					words = BITMAP_WORDS;
				for (f = 0; f < words * BITS_PER_WORD && hit < 0; f++)
					if (!frame_used[f])
						hit = f;
				if (hit < 0) begin
					r.status = ST_NO_FREE;
				end else begin
					frame_used[hit] = 1'b1;
					r.frame      = FRAME_W'(hit);
					r.present    = 1'b1;
					r.writeable  = wr;
					r.supervisor = sup;
					r.status     = ST_ALLOCATED;
				end
			end
		end else if (cur == 0) begin
			r.status = ST_NOTHING;
		end else begin
			frame_used[cur] = 1'b0;
			r.status = ST_FREED;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Leaves s_tvalid high after acceptance so back-to-back requests need no gap.
	task automatic send_request(input logic req, input logic [FRAME_W-1:0] cur,
			input logic sup, input logic wr);
		alloc_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, wr, sup, cur};
		do @(posedge clk); while (!s_tready);
		want = predict_request(req, cur, sup, wr);
		pending_results.push_back(want);
		last_status = want.status;
		if (want.status == ST_ALLOCATED)
			held_frames.push_back(want.frame);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_active_frames(input logic [ACTIVE_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ACTIVE_FRAMES, 2'b00};
		pwdata  <= {19'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		frames_active = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Starts from a clean bitmap, so the first allocation hands out frame zero.
	task automatic test_basic_ops();
		send_request(REQ_ALLOC, 12'd0, 1'b0, 1'b0);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b0);
		send_request(REQ_ALLOC, 12'd0, 1'b0, 1'b1);
		send_request(REQ_ALLOC, 12'd4095, 1'b1, 1'b1);
		send_request(REQ_ALLOC, 12'd1, 1'b0, 1'b1);
		// A page holding frame zero reads as holding none.
		send_request(REQ_FREE, 12'd0, 1'b1, 1'b1);
		send_request(REQ_FREE, 12'd2, 1'b0, 1'b0);
		send_request(REQ_FREE, 12'd2, 1'b1, 1'b0);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1);
		send_request(REQ_FREE, 12'd4095, 1'b0, 1'b1);
		send_request(REQ_FREE, 12'd3, 1'b1, 1'b1);
	endtask

	task automatic test_active_limits();
		wait_drain();
		write_active_frames(13'd0);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1);
		wait_drain();
		write_active_frames(13'd31);
		send_request(REQ_ALLOC, 12'd0, 1'b0, 1'b1);
		// Stored frames outside the active count can still be freed.
		send_request(REQ_FREE, 12'd1, 1'b0, 1'b0);
		wait_drain();
		write_active_frames(13'd32);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b0);
		wait_drain();
		write_active_frames(13'd33);
		send_request(REQ_ALLOC, 12'd0, 1'b0, 1'b0);
		wait_drain();
		write_active_frames(13'd8191);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1);
	endtask

	// Mostly allocations and frees of frames actually held, with some
	// requests on arbitrary frames mixed in.
	task automatic run_random(input int count, input logic [ACTIVE_W-1:0] active);
		int n;
		int pick;
		int idx;
		int f;
		wait_drain();
		write_active_frames(active);
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_request(REQ_ALLOC, 12'd0, rand_bit(), rand_bit());
			end else if (pick < 70 && held_frames.size() != 0) begin
				idx = $urandom_range(held_frames.size() - 1);
				f   = held_frames[idx];
				held_frames.delete(idx);
				send_request(REQ_FREE, FRAME_W'(f), rand_bit(), rand_bit());
			end else if (pick < 80) begin
				send_request(REQ_ALLOC, FRAME_W'($urandom_range(4095, 1)), rand_bit(), rand_bit());
			end else if (pick < 94) begin
				send_request(REQ_FREE, FRAME_W'($urandom_range(4095)), rand_bit(), rand_bit());
			end else if (pick < 97) begin
				send_request(REQ_FREE, 12'd0, rand_bit(), rand_bit());
			end else begin
				send_request(REQ_ALLOC, FRAME_W'($urandom_range(4095)), rand_bit(), rand_bit());
			end
			if ($urandom_range(99) == 0)
				wait_drain();
		end
	endtask

	// The receiver holds off while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		int n;
		int f;
		hold_go = 1'b1;
		for (n = 0; n < 24; n++) begin
			if (n % 2 == 1 && held_frames.size() != 0) begin
				f = held_frames.pop_front();
				send_request(REQ_FREE, FRAME_W'(f), rand_bit(), rand_bit());
			end else begin
				send_request(REQ_ALLOC, 12'd0, rand_bit(), rand_bit());
			end
		end
		wait_drain();
		for (n = 0; n < 6; n++)
			send_request(REQ_ALLOC, 12'd0, rand_bit(), rand_bit());
	endtask

	// Fills the first two bitmap words until the block runs out of frames,
	// then releases every frame in them again.
	task automatic test_fill_and_cap();
		int no_free_seen;
		int f;
		no_free_seen = 0;
		wait_drain();
		write_active_frames(13'd64);
		while (no_free_seen < 2) begin
			send_request(REQ_ALLOC, 12'd0, rand_bit(), rand_bit());
			if (last_status == ST_NO_FREE)
				no_free_seen++;
		end
		wait_drain();
		write_active_frames(13'd4096);
		send_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1);
		for (f = 0; f < 2 * BITS_PER_WORD; f++)
			send_request(REQ_FREE, FRAME_W'(f), rand_bit(), rand_bit());
		held_frames.delete();
	endtask

	always @(posedge clk) begin : result_check
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.frame      = m_tdata[11:0];
			got.present    = m_tdata[12];
			got.writeable  = m_tdata[13];
			got.supervisor = m_tdata[14];
			got.status     = m_tdata[17:15];
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding", got.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.frame !== want.frame)
					report_mismatch("frame_number", got.frame, want.frame);
				if (got.present !== want.present)
					report_mismatch("present_flag", got.present, want.present);
				if (got.writeable !== want.writeable)
					report_mismatch("writeable_flag", got.writeable, want.writeable);
				if (got.supervisor !== want.supervisor)
					report_mismatch("supervisor_flag", got.supervisor, want.supervisor);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
			end
		end
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 52;
		test_basic_ops();
		test_active_limits();
		run_random(150, 13'd96);

		send_idle_pct = 52;
		recv_idle_pct = 11;
		run_random(120, 13'd8191);
		run_random(120, 13'd64);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(150, 13'd4096);
		test_backpressure();
		test_fill_and_cap();

		wait_drain();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
